[design/bcfa_pkg.sv]
// ----------------------------------------------------------------------------
// bcfa_pkg
// Shared types and constants for the contiguous frame allocator.
// ----------------------------------------------------------------------------
package bcfa_pkg;
    localparam int FRAMES    = 1024;
    localparam int MAX_RUN   = 64;
    localparam int WORD_W    = 64;
    localparam int MAP_WORDS = FRAMES / WORD_W;
    localparam int FRAME_W   = $clog2(FRAMES);
    localparam int WIDX_W    = $clog2(MAP_WORDS);
    localparam int BIT_W     = $clog2(WORD_W);
    localparam int CNT_W     = FRAME_W + 1;
    localparam int LEN_W     = 7;
    localparam int ACT_W     = 2;
    localparam int STREAK_W  = $clog2(MAX_RUN + 1);

    typedef enum logic [ACT_W-1:0] {
        ACT_ALLOC   = 2'd0,
        ACT_FREE    = 2'd1,
        ACT_RESERVE = 2'd2,
        ACT_BAD     = 2'd3
    } t_action;

    typedef struct packed {
        logic [ACT_W-1:0]   action;
        logic [LEN_W-1:0]   run_length;
        logic [FRAME_W-1:0] base_frame;
    } t_req;

    typedef struct packed {
        logic               ok;
        logic [FRAME_W-1:0] found_frame;
        logic [CNT_W-1:0]   free_frames;
    } t_rsp;

    typedef enum logic [1:0] {
        CMD_REFUSE = 2'd0,
        CMD_ALLOC  = 2'd1,
        CMD_FREE   = 2'd2,
        CMD_RSV    = 2'd3
    } t_cmd_kind;

    // classified command from front to back
    typedef struct packed {
        t_cmd_kind          kind;
        logic [LEN_W-1:0]   len;
        logic [FRAME_W-1:0] base;
    } t_cmd;
endpackage

[design/bitmap_contiguous_frame_allocator_core.sv]
// ----------------------------------------------------------------------------
// bitmap_contiguous_frame_allocator_core
// First-fit contiguous frame allocator over a 1024-frame bitmap.
// ----------------------------------------------------------------------------
// Request channel (i_valid/o_stall/i_req): allocate, free or reserve a run
// of 1..64 frames. Response channel (o_valid/i_stall/o_rsp): one response
// per request with ok, the allocated base frame and the free frame count.
// A front stage checks length and range and queues up to two commands;
// the back stage walks the bitmap memory one 64-bit word at a time.
// A refused request goes straight to the response. Free or reserve reads and
// writes each touched word (one or two words) in turn. Allocation reads and
// scans one word at a time, up to 16 words, then updates as above; the
// single read port of the bitmap memory sets this word-serial pace.
// One request is carried out at a time.
// After reset the back stage clears all 16 words, marking all frames used;
// queued requests wait for it. The free count resets to zero.
// While the receiver stalls, the response holds, the back stage waits,
// and the request queue fills and then stalls the sender.
// ----------------------------------------------------------------------------
module bitmap_contiguous_frame_allocator_core (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    output logic           o_stall,
    input  bcfa_pkg::t_req i_req,
    output logic           o_valid,
    input  logic           i_stall,
    output bcfa_pkg::t_rsp o_rsp
);
    import bcfa_pkg::*;

    logic w_cmd_valid, w_cmd_pop;
    t_cmd w_cmd;

    bcfa_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_stall     (o_stall),
        .i_req       (i_req),
        .o_cmd_valid (w_cmd_valid),
        .i_cmd_pop   (w_cmd_pop),
        .o_cmd       (w_cmd)
    );

    bcfa_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd_valid (w_cmd_valid),
        .o_cmd_pop   (w_cmd_pop),
        .i_cmd       (w_cmd),
        .o_valid     (o_valid),
        .i_stall     (i_stall),
        .o_rsp       (o_rsp)
    );
endmodule

[design/bcfa_front.sv]
// ----------------------------------------------------------------------------
// bcfa_front
// Accepts requests, checks length and range, and queues classified commands.
// ----------------------------------------------------------------------------
module bcfa_front (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    output logic           o_stall,
    input  bcfa_pkg::t_req i_req,
    output logic           o_cmd_valid,
    input  logic           i_cmd_pop,
    output bcfa_pkg::t_cmd o_cmd
);
    import bcfa_pkg::*;

    t_cmd       r_q [2];
    logic       r_wp, r_rp;
    logic [1:0] r_cnt;
    t_cmd       w_cmd;
    logic       w_push;
    logic       w_len_ok;
    logic [FRAME_W:0] w_end;

    always_comb begin
        w_len_ok = (i_req.run_length != '0) &&
                   (i_req.run_length <= LEN_W'(MAX_RUN));
        w_end = {1'b0, i_req.base_frame} + (FRAME_W+1)'(i_req.run_length);
        w_cmd.len  = i_req.run_length;
        w_cmd.base = i_req.base_frame;
        w_cmd.kind = CMD_REFUSE;
        if (w_len_ok) begin
            unique case (t_action'(i_req.action))
                ACT_ALLOC:   w_cmd.kind = CMD_ALLOC;
                ACT_FREE:    if (w_end <= (FRAME_W+1)'(FRAMES)) w_cmd.kind = CMD_FREE;
                ACT_RESERVE: if (w_end <= (FRAME_W+1)'(FRAMES)) w_cmd.kind = CMD_RSV;
                default:     w_cmd.kind = CMD_REFUSE;
            endcase
        end
    end

    assign o_stall     = (r_cnt == 2'd2);
    assign w_push      = i_valid && !o_stall;
    assign o_cmd_valid = (r_cnt != 2'd0);
    assign o_cmd       = r_q[r_rp];

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_q[r_wp] <= w_cmd;
        end
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (w_push) r_wp <= ~r_wp;
            if (i_cmd_pop && o_cmd_valid) r_rp <= ~r_rp;
            r_cnt <= r_cnt + 2'(w_push) - 2'(i_cmd_pop && o_cmd_valid);
        end
    end

    assert property (@(posedge i_clk) disable iff (!i_rst_n) r_cnt <= 2'd2)
        else $error("queue overflow");
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd_pop |-> o_cmd_valid) else $error("pop from empty queue");
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_cnt == 2'd0) |-> (r_wp == r_rp)) else $error("pointer mismatch");
endmodule

[design/bcfa_back.sv]
// ----------------------------------------------------------------------------
// bcfa_back
// Bitmap memory, word-serial first-fit search, run update and response.
// ----------------------------------------------------------------------------
module bcfa_back (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_cmd_valid,
    output logic           o_cmd_pop,
    input  bcfa_pkg::t_cmd i_cmd,
    output logic           o_valid,
    input  logic           i_stall,
    output bcfa_pkg::t_rsp o_rsp
);
    import bcfa_pkg::*;

    typedef enum logic [2:0] {
        S_CLR, S_IDLE, S_SCAN_RD, S_SCAN, S_UPD_RD, S_UPD, S_RESP
    } t_state;

    logic [WORD_W-1:0] r_mem [MAP_WORDS];
    logic [WORD_W-1:0] r_rd;

    t_state             r_state;
    t_cmd               r_cmd;
    logic [WIDX_W:0]    r_widx;
    logic [STREAK_W-1:0] r_streak;
    logic [FRAME_W-1:0] r_found;
    logic [FRAME_W:0]   r_pos;
    logic [LEN_W-1:0]   r_left;
    logic [CNT_W-1:0]   r_free;
    logic               r_ok;
    logic               r_valid;
    t_rsp               r_rsp;

    logic               w_rd_en, w_wr_en;
    logic [WIDX_W-1:0]  w_rd_a, w_wr_a;
    logic [WORD_W-1:0]  w_wr_d;

    // scan one word: a run ends at bit b when its whole window is free
    logic [WORD_W-1:0]   w_free;
    logic [WORD_W-1:0]   w_lt;
    logic [WORD_W-1:0]   w_end_ok;
    logic [STREAK_W-1:0] w_s;
    logic                w_hit;
    logic [BIT_W-1:0]    w_hit_bit;
    always_comb begin
        w_free = ~r_rd;
        if (r_widx[WIDX_W-1:0] == '0) w_free[0] = 1'b0;
        for (int d = 0; d < WORD_W; d++) begin
            w_lt[d] = (d < int'(r_cmd.len));
        end
        for (int b = 0; b < WORD_W; b++) begin
            w_end_ok[b] = ((int'(r_streak) + b + 1) >= int'(r_cmd.len));
            for (int j = 0; j <= b; j++) begin
                if (w_lt[b-j] && !w_free[j]) w_end_ok[b] = 1'b0;
            end
        end
        w_hit = 1'b0;
        w_hit_bit = '0;
        for (int b = WORD_W - 1; b >= 0; b--) begin
            if (w_end_ok[b]) begin
                w_hit = 1'b1;
                w_hit_bit = BIT_W'(b);
            end
        end
        w_s = STREAK_W'(WORD_W);
        for (int b = 0; b < WORD_W; b++) begin
            if (!w_free[b]) w_s = STREAK_W'(WORD_W - 1 - b);
        end
    end

    // update mask over current word
    logic [BIT_W-1:0]  w_lo;
    logic [BIT_W:0]    w_room;
    logic [LEN_W-1:0]  w_take;
    logic [WORD_W-1:0] w_mask, w_new, w_chg;
    logic              w_set;
    logic [CNT_W-1:0]  w_pop;
    always_comb begin
        w_lo   = r_pos[BIT_W-1:0];
        w_room = (BIT_W+1)'(WORD_W) - (BIT_W+1)'(w_lo);
        w_take = ({1'b0, r_left} > (LEN_W+1)'(w_room)) ? LEN_W'(w_room) : r_left;
        w_mask = '0;
        for (int b = 0; b < WORD_W; b++) begin
            if (b >= w_lo && (b - w_lo) < w_take) w_mask[b] = 1'b1;
        end
        w_set = (r_cmd.kind != CMD_FREE);
        w_new = w_set ? (r_rd | w_mask) : (r_rd & ~w_mask);
        w_chg = w_new ^ r_rd;
        w_pop = CNT_W'($countones(w_chg));
    end

    always_comb begin
        w_rd_en = 1'b0;
        w_rd_a  = r_widx[WIDX_W-1:0];
        w_wr_en = 1'b0;
        w_wr_a  = r_widx[WIDX_W-1:0];
        w_wr_d  = w_new;
        unique case (r_state)
            S_CLR: begin
                w_wr_en = 1'b1;
                w_wr_d  = '1;
            end
            S_SCAN_RD: w_rd_en = 1'b1;
            S_UPD_RD: begin
                w_rd_en = 1'b1;
                w_rd_a  = r_pos[FRAME_W-1:BIT_W];
            end
            S_UPD: begin
                w_wr_en = 1'b1;
                w_wr_a  = r_pos[FRAME_W-1:BIT_W];
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (w_wr_en) r_mem[w_wr_a] <= w_wr_d;
        if (w_rd_en) r_rd <= r_mem[w_rd_a];
    end

    assign o_cmd_pop = (r_state == S_IDLE) && i_cmd_valid;
    assign o_valid   = r_valid;
    assign o_rsp     = r_rsp;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_CLR;
            r_widx   <= '0;
            r_free   <= '0;
            r_valid  <= 1'b0;
            r_streak <= '0;
        end else begin
            if (r_valid && !i_stall && r_state != S_RESP) r_valid <= 1'b0;
            unique case (r_state)
                S_CLR: begin
                    r_widx <= r_widx + 1'b1;
                    if (r_widx == (WIDX_W+1)'(MAP_WORDS - 1)) r_state <= S_IDLE;
                end
                S_IDLE: begin
                    if (i_cmd_valid) begin
                        r_cmd    <= i_cmd;
                        r_widx   <= '0;
                        r_streak <= '0;
                        r_ok     <= 1'b0;
                        r_found  <= '0;
                        r_pos    <= {1'b0, i_cmd.base};
                        r_left   <= i_cmd.len;
                        unique case (i_cmd.kind)
                            CMD_ALLOC:  r_state <= S_SCAN_RD;
                            CMD_REFUSE: r_state <= S_RESP;
                            default:    r_state <= S_UPD_RD;
                        endcase
                    end
                end
                S_SCAN_RD: r_state <= S_SCAN;
                S_SCAN: begin
                    r_streak <= w_s;
                    if (w_hit) begin
                        r_found <= FRAME_W'({r_widx[WIDX_W-1:0], w_hit_bit}
                                   - (FRAME_W)'(r_cmd.len) + 1'b1);
                        r_pos   <= (FRAME_W+1)'({r_widx[WIDX_W-1:0], w_hit_bit}
                                   - (FRAME_W)'(r_cmd.len) + 1'b1);
                        r_state <= S_UPD_RD;
                    end else if (r_widx == (WIDX_W+1)'(MAP_WORDS - 1)) begin
                        r_state <= S_RESP;
                    end else begin
                        r_widx  <= r_widx + 1'b1;
                        r_state <= S_SCAN_RD;
                    end
                end
                S_UPD_RD: r_state <= S_UPD;
                S_UPD: begin
                    r_free <= w_set ? (r_free - w_pop) : (r_free + w_pop);
                    r_pos  <= r_pos + (FRAME_W+1)'(w_take);
                    r_left <= r_left - w_take;
                    if (r_left == w_take) begin
                        r_ok    <= 1'b1;
                        r_state <= S_RESP;
                    end else begin
                        r_state <= S_UPD_RD;
                    end
                end
                S_RESP: begin
                    if (!r_valid || !i_stall) begin
                        r_valid <= 1'b1;
                        r_rsp.ok          <= r_ok;
                        r_rsp.found_frame <= r_found;
                        r_rsp.free_frames <= r_free;
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_free <= CNT_W'(FRAMES)) else $error("free count out of range");
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_valid && i_stall) |=> r_valid) else $error("response dropped");
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd_pop |-> (r_state == S_IDLE)) else $error("pop while busy");
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_RESP && r_cmd.kind == CMD_REFUSE) |-> !r_ok)
        else $error("refused command reported ok");
endmodule

[tb/bitmap_contiguous_frame_allocator_core_tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bitmap_contiguous_frame_allocator_core_tb
// Drives allocate, free and reserve runs into the allocator. A behavioral
// bitmap predicts each response, and every response is checked in order.
// ----------------------------------------------------------------------------
module bitmap_contiguous_frame_allocator_core_tb;
    import bcfa_pkg::*;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_valid = 1'b0;
    logic o_stall;
    t_req i_req = '0;
    logic o_valid;
    logic i_stall = 1'b0;
    t_rsp o_rsp;

    bitmap_contiguous_frame_allocator_core dut (.*);

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    logic [FRAMES-1:0] used_map;
    int unsigned free_cnt;
    t_req pending_reqs[$];
    t_rsp expected_rsps[$];
    int mismatches = 0;
    bit stim_done = 0;
    bit hold_rx = 0;
    int send_gap = 0;
    int rx_gap = 0;

    function automatic t_rsp predict_rsp(t_req r);
        t_rsp p;
        int len, streak, found;
        bit mark;
        p = '0;
        len = r.run_length;
        found = 0;
        streak = 0;
        if (len >= 1 && len <= MAX_RUN) begin
            if (r.action == ACT_ALLOC) begin
                for (int f = 1; f < FRAMES && found == 0; f++) begin
                    if (used_map[f]) begin
                        streak = 0;
                    end else begin
                        streak++;
                        if (streak == len) found = f + 1 - len;
                    end
                end
                if (found != 0) begin
                    for (int f = found; f < found + len; f++) begin
                        used_map[f] = 1'b1;
                        free_cnt--;
                    end
                    p.ok = 1'b1;
                end
            end else if (r.action == ACT_FREE || r.action == ACT_RESERVE) begin
                if (int'(r.base_frame) + len <= FRAMES) begin
                    mark = (r.action == ACT_RESERVE);
                    for (int f = r.base_frame; f < int'(r.base_frame) + len; f++) begin
                        if (used_map[f] != mark) begin
                            used_map[f] = mark;
                            if (mark) free_cnt--;
                            else free_cnt++;
                        end
                    end
                    p.ok = 1'b1;
                end
            end
        end
        p.found_frame = found[FRAME_W-1:0];
        p.free_frames = free_cnt[CNT_W-1:0];
        return p;
    endfunction

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 50) return 0;
        if (r < 95) return $urandom_range(1, 4);
        return $urandom_range(10, 60);
    endfunction

    function automatic t_req make_req(t_action a, int len, int base);
        t_req r;
        r.action = a;
        r.run_length = len[LEN_W-1:0];
        r.base_frame = base[FRAME_W-1:0];
        return r;
    endfunction

    // driver
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (!i_valid || !o_stall) begin
                if (send_gap > 0 || pending_reqs.size() == 0) begin
                    i_valid <= 1'b0;
                    if (send_gap > 0) send_gap <= send_gap - 1;
                end else begin
                    i_req <= pending_reqs[0];
                    expected_rsps.push_back(predict_rsp(pending_reqs[0]));
                    void'(pending_reqs.pop_front());
                    i_valid <= 1'b1;
                    send_gap <= pick_gap();
                end
            end
        end
    end

    // monitor and receiver stall
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_valid && !i_stall) begin
                if (expected_rsps.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10) $display("unexpected response %p", o_rsp);
                end else begin
                    if (o_rsp.ok !== expected_rsps[0].ok ||
                        o_rsp.found_frame !== expected_rsps[0].found_frame ||
                        o_rsp.free_frames !== expected_rsps[0].free_frames) begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("mismatch: expected %p actual %p",
                                     expected_rsps[0], o_rsp);
                    end
                    void'(expected_rsps.pop_front());
                end
            end
            if (hold_rx) begin
                i_stall <= 1'b1;
            end else if (rx_gap > 0) begin
                i_stall <= 1'b1;
                rx_gap <= rx_gap - 1;
            end else begin
                i_stall <= 1'b0;
                rx_gap <= pick_gap();
            end
        end
    end

    task automatic wait_drained();
        while (pending_reqs.size() != 0 || expected_rsps.size() != 0 || i_valid)
            @(posedge i_clk);
    endtask

    task automatic add_random(int n, bit quiet);
        int len, base, r;
        t_action a;
        for (int k = 0; k < n; k++) begin
            r = $urandom_range(0, 99);
            if (r < 45) a = ACT_ALLOC;
            else if (r < 75) a = ACT_FREE;
            else if (r < 95) a = ACT_RESERVE;
            else a = ACT_BAD;
            r = $urandom_range(0, 99);
            if (r < 60) len = $urandom_range(1, 8);
            else if (r < 90) len = $urandom_range(1, MAX_RUN);
            else len = $urandom_range(0, 127);
            if ($urandom_range(0, 9) < 8) base = $urandom_range(0, FRAMES - len - 1);
            else base = $urandom_range(0, FRAMES - 1);
            if (base < 0) base = 0;
            pending_reqs.push_back(make_req(a, len, base));
            if (!quiet && $urandom_range(0, 9) == 0) wait_drained();
        end
    endtask

    initial begin
        used_map = '1;
        free_cnt = 0;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed: edges, refusals, all actions
        pending_reqs.push_back(make_req(ACT_ALLOC, 1, 0));
        pending_reqs.push_back(make_req(ACT_FREE, 64, 0));
        pending_reqs.push_back(make_req(ACT_ALLOC, 64, 0));
        pending_reqs.push_back(make_req(ACT_ALLOC, 1, 0));
        pending_reqs.push_back(make_req(ACT_FREE, 64, 960));
        pending_reqs.push_back(make_req(ACT_FREE, 64, 961));
        pending_reqs.push_back(make_req(ACT_FREE, 1, 1023));
        pending_reqs.push_back(make_req(ACT_FREE, 0, 100));
        pending_reqs.push_back(make_req(ACT_FREE, 65, 100));
        pending_reqs.push_back(make_req(ACT_FREE, 127, 100));
        pending_reqs.push_back(make_req(ACT_FREE, 30, 100));
        pending_reqs.push_back(make_req(ACT_FREE, 30, 100));
        pending_reqs.push_back(make_req(ACT_RESERVE, 5, 110));
        pending_reqs.push_back(make_req(ACT_RESERVE, 5, 110));
        pending_reqs.push_back(make_req(ACT_ALLOC, 10, 0));
        pending_reqs.push_back(make_req(ACT_ALLOC, 64, 0));
        pending_reqs.push_back(make_req(ACT_BAD, 4, 200));
        pending_reqs.push_back(make_req(ACT_RESERVE, 64, 960));
        pending_reqs.push_back(make_req(ACT_FREE, 64, 512));
        pending_reqs.push_back(make_req(ACT_ALLOC, 33, 1023));
        pending_reqs.push_back(make_req(ACT_FREE, 64, 63));
        pending_reqs.push_back(make_req(ACT_ALLOC, 64, 0));
        pending_reqs.push_back(make_req(ACT_ALLOC, 0, 0));
        wait_drained();

        // open all of memory, then churn
        for (int b = 0; b < FRAMES; b += 64)
            pending_reqs.push_back(make_req(ACT_FREE, 64, b));
        add_random(500, 0);
        wait_drained();

        // long receiver hold while sender keeps offering
        hold_rx = 1;
        add_random(40, 1);
        repeat (300) @(posedge i_clk);
        hold_rx = 0;
        wait_drained();

        add_random(940, 0);
        wait_drained();
        repeat (60) @(posedge i_clk);
        stim_done = 1;
    end

    initial begin
        wait (stim_done);
        if (mismatches == 0 && expected_rsps.size() == 0) begin
            $display("bitmap_contiguous_frame_allocator_core_tb: PASS");
        end else begin
            $display("bitmap_contiguous_frame_allocator_core_tb: FAIL");
        end
        $finish;
    end

    initial begin
        #2000000;
        $display("bitmap_contiguous_frame_allocator_core_tb: FAIL");
        $finish;
    end
endmodule

[sim.f]
design/bcfa_pkg.sv
design/bcfa_front.sv
design/bcfa_back.sv
design/bitmap_contiguous_frame_allocator_core.sv
tb/bitmap_contiguous_frame_allocator_core_tb.sv
